// ===== src/key_matrix_debounce_pulse_defines.svh =====
// Assertion macros used by the key matrix debounce checker.
`ifndef KEY_MATRIX_DEBOUNCE_PULSE_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_PULSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define KMD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KMD_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kmd_pkg.sv =====
// Types and constants of the key matrix debouncer.
package kmd_pkg;

    localparam int ROW_W      = 3;
    localparam int COLS_W     = 5;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int MASK_W     = 30;
    localparam int BUTTON_W   = 5;
    localparam int KEY_CALC_W = 8;
    localparam int MASK_IDX_W = 5;
    localparam int PULSE_KEYS = 30;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd20;
    localparam logic [MS_W-1:0]   PULSE_RST    = 16'd100;
    localparam logic [MASK_W-1:0] MASK_RST     = 30'h1EF40210;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_PULSE    = 2'd1,
        CFG_MASK     = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_SCAN   = 1'b0,
        OP_EXPIRE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_COLLECT = 2'b10
    } t_state;

    typedef struct packed {
        logic              en;
        t_op               op;
        logic [TIME_W-1:0] now;
        logic [MS_W-1:0]   debounce;
        logic [MS_W-1:0]   pulse_ms;
    } t_lane_cmd;

    typedef struct packed {
        logic hit;
        logic on;
    } t_lane_res;

    typedef struct packed {
        logic clear;
        logic cap;
        logic start;
    } t_merge_ctl;

endpackage

// ===== src/kmd_if.sv =====
// Valid/ready channels for scan items and key events.
interface kmd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [kmd_pkg::ROW_W-1:0]   row;
    logic [kmd_pkg::COLS_W-1:0]  column_bits;
    logic [kmd_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, op, row, column_bits, now_ms, input ready);
    modport sink   (input valid, op, row, column_bits, now_ms, output ready);
endinterface

interface kmd_out_if;
    logic                         valid;
    logic                         ready;
    logic [kmd_pkg::BUTTON_W-1:0] button;
    logic                         button_on;
    logic                         last_in_run;

    modport source (output valid, button, button_on, last_in_run, input ready);
    modport sink   (input valid, button, button_on, last_in_run, output ready);
endinterface

// ===== src/kmd_lane.sv =====
// One column lane: per-row debounce and pulse state for a single matrix column.
module kmd_lane #(
    parameter int ROW_COUNT = 6
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  kmd_pkg::t_lane_cmd                       i_cmd,
    input  logic [(ROW_COUNT > 1 ? $clog2(ROW_COUNT) : 1)-1:0] i_row,
    input  logic                                     i_level,
    input  logic                                     i_pulse,
    output kmd_pkg::t_lane_res                       o_res
);
    logic [ROW_COUNT-1:0]         r_raw;
    logic [ROW_COUNT-1:0]         r_stable;
    logic [ROW_COUNT-1:0]         r_pa;
    logic [kmd_pkg::TIME_W-1:0]   r_ct [ROW_COUNT];
    logic [kmd_pkg::TIME_W-1:0]   r_ps [ROW_COUNT];

    logic [kmd_pkg::TIME_W-1:0]   n_ct;
    logic [kmd_pkg::TIME_W-1:0]   ct_age;
    logic [kmd_pkg::TIME_W-1:0]   ps_age;
    logic                         scan_hit;
    logic                         exp_hit;

    // A fresh edge restarts the stable timer at the current time.
    assign n_ct     = (i_level != r_raw[i_row]) ? i_cmd.now : r_ct[i_row];
    assign ct_age   = i_cmd.now - n_ct;
    assign ps_age   = i_cmd.now - r_ps[i_row];
    assign scan_hit = (ct_age > {{(kmd_pkg::TIME_W-kmd_pkg::MS_W){1'b0}}, i_cmd.debounce})
                      && (i_level != r_stable[i_row]);
    assign exp_hit  = r_pa[i_row]
                      && (ps_age > {{(kmd_pkg::TIME_W-kmd_pkg::MS_W){1'b0}}, i_cmd.pulse_ms});

    always_comb begin
        if (i_cmd.op == kmd_pkg::OP_SCAN) begin
            o_res.hit = scan_hit;
            o_res.on  = i_pulse | ~i_level;
        end else begin
            o_res.hit = exp_hit;
            o_res.on  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '1;
            r_stable <= '1;
            r_pa     <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_ct[r] <= '0;
                r_ps[r] <= '0;
            end
        end else if (i_cmd.en) begin
            if (i_cmd.op == kmd_pkg::OP_SCAN) begin
                r_raw[i_row] <= i_level;
                r_ct[i_row]  <= n_ct;
                if (scan_hit) begin
                    r_stable[i_row] <= i_level;
                    if (i_pulse) begin
                        r_pa[i_row] <= 1'b1;
                        r_ps[i_row] <= i_cmd.now;
                    end
                end
            end else if (exp_hit) begin
                r_pa[i_row] <= 1'b0;
            end
        end
    end
endmodule

// ===== src/kmd_merge.sv =====
// Merge stage: collects lane hits per row and emits key events in key order.
module kmd_merge #(
    parameter int ROW_COUNT = 6,
    parameter int COL_COUNT = 5
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  kmd_pkg::t_merge_ctl                      i_ctl,
    input  logic [(ROW_COUNT > 1 ? $clog2(ROW_COUNT) : 1)-1:0] i_cap_row,
    input  logic [(ROW_COUNT > 1 ? $clog2(ROW_COUNT) : 1)-1:0] i_start_row,
    input  logic [COL_COUNT-1:0]                     i_hit,
    input  logic [COL_COUNT-1:0]                     i_on,
    output logic                                     o_busy,
    kmd_out_if.source                                o_out
);
    localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int CW = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

    logic [COL_COUNT-1:0]            r_hit [ROW_COUNT];
    logic [COL_COUNT-1:0]            r_on;
    logic                            r_any;
    logic                            r_busy;
    logic [RW-1:0]                   r_erow;
    logic                            r_ovalid;
    logic [kmd_pkg::BUTTON_W-1:0]    r_button;
    logic                            r_bon;
    logic                            r_last;

    logic [COL_COUNT-1:0]            cur;
    logic [COL_COUNT-1:0]            rest;
    logic [CW-1:0]                   pick;
    logic                            later_any;
    logic                            slot_free;
    logic [kmd_pkg::KEY_CALC_W-1:0]  key_calc;

    assign cur       = r_hit[r_erow];
    assign rest      = cur & (cur - COL_COUNT'(1));
    assign slot_free = !r_ovalid || o_out.ready;
    assign key_calc  = kmd_pkg::KEY_CALC_W'(r_erow) * kmd_pkg::KEY_CALC_W'(COL_COUNT)
                       + kmd_pkg::KEY_CALC_W'(pick);

    always_comb begin
        pick = '0;
        for (int c = COL_COUNT - 1; c >= 0; c--) begin
            if (cur[c]) pick = CW'(c);
        end
    end

    always_comb begin
        later_any = 1'b0;
        for (int j = 0; j < ROW_COUNT; j++) begin
            if ((j > int'(r_erow)) && (|r_hit[j])) later_any = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROW_COUNT; j++) r_hit[j] <= '0;
            r_any    <= 1'b0;
            r_busy   <= 1'b0;
            r_erow   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                for (int j = 0; j < ROW_COUNT; j++) r_hit[j] <= '0;
                r_any <= 1'b0;
            end
            if (i_ctl.cap) begin
                r_hit[i_cap_row] <= i_hit;
                r_any            <= r_any | (|i_hit);
            end
            if (i_ctl.start) begin
                r_busy <= r_any | (|i_hit);
                r_erow <= i_start_row;
            end
            if (slot_free) begin
                r_ovalid <= 1'b0;
                if (r_busy) begin
                    if (|cur) begin
                        r_hit[r_erow] <= rest;
                        r_ovalid      <= 1'b1;
                        if (!(|rest) && !later_any) r_busy <= 1'b0;
                    end else begin
                        // skip an empty row
                        r_erow <= r_erow + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) r_on <= i_on;
        if (slot_free && r_busy && (|cur)) begin
            r_button <= key_calc[kmd_pkg::BUTTON_W-1:0];
            r_bon    <= r_on[pick];
            r_last   <= !(|rest) && !later_any;
        end
    end

    assign o_busy            = r_busy;
    assign o_out.valid       = r_ovalid;
    assign o_out.button      = r_button;
    assign o_out.button_on   = r_bon;
    assign o_out.last_in_run = r_last;
endmodule

// ===== src/key_matrix_debounce_pulse.sv =====
// Key matrix debouncer top level: configuration, row sequencer, column lanes, merge.
// A row-scan transaction is accepted in ST_IDLE; in ST_COLLECT all COL_COUNT
// column lanes update the scanned row. Its events (one per key whose debounced
// level changed, in column order) then leave at one per cycle while the output is
// not stalled. An expiry transaction walks the rows through the same lanes, one
// row per cycle, before the merge stage emits its events at one per cycle while
// the output is not stalled, with a gap each time the merge stage moves on from a
// row to the next one, up to the last row that holds an event. The next
// transaction is taken once the final event of the current one sits in the output
// register; a transaction without events frees the input right after its last
// lane cycle. Scans with a row at or above ROW_COUNT are dropped on acceptance.
// Configuration writes take effect on the following cycle. State is ready right out of reset.
module key_matrix_debounce_pulse #(
    parameter int ROW_COUNT = 6,
    parameter int COL_COUNT = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kmd_pkg::MASK_W-1:0]      i_cfg_data,
    kmd_in_if.sink                          i_in,
    kmd_out_if.source                       o_out
);
    localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic [kmd_pkg::MS_W-1:0]    r_debounce;
    logic [kmd_pkg::MS_W-1:0]    r_pulse_ms;
    logic [kmd_pkg::MASK_W-1:0]  r_mask;

    kmd_pkg::t_state             r_state, n_state;
    logic [RW-1:0]               r_row, n_row;
    kmd_pkg::t_op                r_op;
    logic [kmd_pkg::COLS_W-1:0]  r_cols;
    logic [kmd_pkg::TIME_W-1:0]  r_now;

    logic                        busy;
    logic                        accept;
    logic                        row_ok;
    logic                        last_row;
    kmd_pkg::t_lane_cmd          lane_cmd;
    kmd_pkg::t_lane_res          lane_res [COL_COUNT];
    logic [COL_COUNT-1:0]        lane_level;
    logic [COL_COUNT-1:0]        lane_pulse;
    logic [COL_COUNT-1:0]        lane_hit;
    logic [COL_COUNT-1:0]        lane_on;
    kmd_pkg::t_merge_ctl         merge_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kmd_pkg::DEBOUNCE_RST;
            r_pulse_ms <= kmd_pkg::PULSE_RST;
            r_mask     <= kmd_pkg::MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kmd_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[kmd_pkg::MS_W-1:0];
                kmd_pkg::CFG_PULSE:    r_pulse_ms <= i_cfg_data[kmd_pkg::MS_W-1:0];
                kmd_pkg::CFG_MASK:     r_mask     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == kmd_pkg::ST_IDLE) && !busy;
    assign accept     = i_in.valid && i_in.ready;
    assign row_ok     = (i_in.op == kmd_pkg::OP_EXPIRE) || (int'(i_in.row) < ROW_COUNT);
    assign last_row   = (r_op == kmd_pkg::OP_SCAN) || (r_row == RW'(ROW_COUNT - 1));

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        merge_ctl = '0;
        unique case (r_state)
            kmd_pkg::ST_IDLE: begin
                if (accept && row_ok) begin
                    merge_ctl.clear = 1'b1;
                    n_state         = kmd_pkg::ST_COLLECT;
                    n_row           = (i_in.op == kmd_pkg::OP_SCAN) ? RW'(i_in.row) : '0;
                end
            end
            kmd_pkg::ST_COLLECT: begin
                merge_ctl.cap = 1'b1;
                if (last_row) begin
                    merge_ctl.start = 1'b1;
                    n_state         = kmd_pkg::ST_IDLE;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            default: n_state = kmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmd_pkg::ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // hold the transaction payload for the lane cycles
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= kmd_pkg::t_op'(i_in.op);
            r_cols <= i_in.column_bits;
            r_now  <= i_in.now_ms;
        end
    end

    assign lane_cmd.en       = (r_state == kmd_pkg::ST_COLLECT);
    assign lane_cmd.op       = r_op;
    assign lane_cmd.now      = r_now;
    assign lane_cmd.debounce = r_debounce;
    assign lane_cmd.pulse_ms = r_pulse_ms;

    for (genvar c = 0; c < COL_COUNT; c++) begin : g_lane
        logic [kmd_pkg::KEY_CALC_W-1:0] key_calc;

        if (c < kmd_pkg::COLS_W) begin : g_col
            assign lane_level[c] = r_cols[c];
        end else begin : g_nocol
            // columns beyond the input field read closed
            assign lane_level[c] = 1'b0;
        end

        assign key_calc = kmd_pkg::KEY_CALC_W'(r_row) * kmd_pkg::KEY_CALC_W'(COL_COUNT)
                          + kmd_pkg::KEY_CALC_W'(c);
        assign lane_pulse[c] = (key_calc < kmd_pkg::KEY_CALC_W'(kmd_pkg::PULSE_KEYS))
                               && r_mask[key_calc[kmd_pkg::MASK_IDX_W-1:0]];

        kmd_lane #(
            .ROW_COUNT (ROW_COUNT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd),
            .i_row   (r_row),
            .i_level (lane_level[c]),
            .i_pulse (lane_pulse[c]),
            .o_res   (lane_res[c])
        );

        assign lane_hit[c] = lane_res[c].hit;
        assign lane_on[c]  = lane_res[c].on;
    end

    kmd_merge #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (merge_ctl),
        .i_cap_row   (r_row),
        .i_start_row ((r_op == kmd_pkg::OP_SCAN) ? r_row : RW'(0)),
        .i_hit       (lane_hit),
        .i_on        (lane_on),
        .o_busy      (busy),
        .o_out       (o_out)
    );
endmodule

// ===== src/kmd_check.sv =====
// Port-level checker for the key matrix debouncer, bound to the top level.
`include "key_matrix_debounce_pulse_defines.svh"

module kmd_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_op,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [kmd_pkg::BUTTON_W-1:0]  i_out_button,
    input logic                          i_out_button_on,
    input logic                          i_out_last
);
    // a stalled event holds its payload
    `KMD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_button) && $stable(i_out_button_on) && $stable(i_out_last), "stalled event changed")

    // reset empties the output register
    `KMD_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid, "event shown after reset")

    // no new transaction while the current one still has events to send
    `KMD_ASSERT(a_run_blocks, i_out_valid && !i_out_last, !i_in_ready, "input open mid run")

    // an expiry pass occupies the sequencer on the next cycle
    `KMD_ASSERT_NEXT(a_expire_busy, i_in_valid && i_in_ready && (i_in_op == kmd_pkg::OP_EXPIRE), !i_in_ready, "input open during expiry")
endmodule

bind key_matrix_debounce_pulse kmd_check u_kmd_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_op         (i_in.op),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_button    (o_out.button),
    .i_out_button_on (o_out.button_on),
    .i_out_last      (o_out.last_in_run)
);
